// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes of the page frame allocator
// Field widths, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // word field widths
  localparam int OP_W     = 3;
  localparam int FRAME_W  = 12;
  localparam int STATUS_W = 3;
  localparam int REFCNT_W = 8;
  localparam int FREECNT_W = 13;

  // operation codes; the unused codes behave as a count read
  localparam logic [OP_W-1:0] OP_SEED  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd2;
  localparam logic [OP_W-1:0] OP_INC   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd4;
  localparam logic [OP_W-1:0] OP_READ  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_LIMIT = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ----- rtl/pfa_ifs.sv -----
// ----------------------------------------------------------------------------
// pfa request and response channels
// Valid/ready channels carrying one operation word and one result word.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [FRAME_W-1:0]  frame;

  modport source (output valid, output operation, output frame, input ready);
  modport sink   (input valid, input operation, input frame, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [FRAME_W-1:0]   frame_out;
  logic [REFCNT_W-1:0]  ref_count;
  logic [FREECNT_W-1:0] free_count;

  modport source (output valid, output status, output frame_out, output ref_count,
                  output free_count, input ready);
  modport sink   (input valid, input status, input frame_out, input ref_count,
                  input free_count, output ready);
endinterface

// ----- rtl/page_frame_allocator_refcount_top.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_top: LIFO free frame list with ref counts
// Free stack and per-frame count table in two registered-read memories.
// ----------------------------------------------------------------------------
// flow: a new word is taken only in the idle state, so the memory read and the
//   write-back of the same count and stack entry of one word finish before the
//   next word is taken
// reset: after rst the count table is zeroed, one entry a cycle, with req.ready low
//   until every entry is clear; the register writes are taken throughout
module page_frame_allocator_refcount_top import pfa_pkg::*; #(
  parameter int NUM_FRAMES = 4096,
  parameter int COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  pfa_req_if.sink            req,
  pfa_rsp_if.source          rsp,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata
);

  localparam int AW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FILLW = $clog2(NUM_FRAMES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [FILLW-1:0]      FILL_MAX = FILLW'(NUM_FRAMES);
  localparam logic [AW-1:0]         LAST_IDX = AW'(NUM_FRAMES - 1);

  // memories
  logic [FRAME_W-1:0]    stack_mem [NUM_FRAMES];
  logic [COUNT_BITS-1:0] ref_mem   [NUM_FRAMES];

  state_t                state, state_next;
  logic [FRAME_W-1:0]    first_usable;
  logic [FILLW-1:0]      fill, fill_next;
  logic [AW-1:0]         clr_addr;
  logic [OP_W-1:0]       op_q;
  logic [FRAME_W-1:0]    frame_q;
  logic [FRAME_W-1:0]    stack_rd;
  logic [COUNT_BITS-1:0] ref_rd;

  logic                  accept, clr_we, go;
  logic                  ref_we;
  logic [AW-1:0]         ref_wa;
  logic [COUNT_BITS-1:0] ref_wd;
  logic                  do_push;
  logic [STATUS_W-1:0]   sts;
  logic [FRAME_W-1:0]    fout;
  logic [COUNT_BITS-1:0] cnt;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [FRAME_W-1:0]    out_frame;
  logic [REFCNT_W-1:0]   out_refcnt;
  logic [FREECNT_W-1:0]  out_freecnt;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= '0;
    end else if (cfg_we) begin
      first_usable <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_EXEC;
      ST_EXEC:  if (go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    req.ready = 1'b0;
    clr_we    = 1'b0;
    go        = 1'b0;
    unique case (state)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  req.ready = 1'b1;
      ST_EXEC:  go = !out_valid || rsp.ready;
      default:  ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      fill     <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (clr_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // capture the word; memory reads go out on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      frame_q <= req.frame;
    end
  end

  function automatic logic req_frame_ok(input logic [FRAME_W-1:0] f);
    req_frame_ok = (f >= first_usable) && (32'(f) < NUM_FRAMES);
  endfunction

  // execute: modify counts and stack pointer from the read data
  always_comb begin
    logic                  in_range;
    logic                  push_req;
    logic [COUNT_BITS-1:0] dec;
    in_range  = (req_frame_ok(frame_q));
    push_req  = 1'b0;
    dec       = (ref_rd != '0) ? ref_rd - 1'b1 : ref_rd;
    sts       = STS_OK;
    fout      = frame_q;
    cnt       = '0;
    ref_we    = 1'b0;
    ref_wa    = AW'(frame_q);
    ref_wd    = ref_rd;
    do_push   = 1'b0;
    fill_next = fill;
    if (op_q == OP_ALLOC) begin
      if (fill == '0) begin
        sts  = STS_EMPTY;
        fout = '0;
      end else begin
        fout      = stack_rd;
        cnt       = COUNT_BITS'(1);
        ref_wa    = AW'(stack_rd);
        ref_wd    = COUNT_BITS'(1);
        ref_we    = go && (32'(stack_rd) < NUM_FRAMES);
        fill_next = go ? fill - 1'b1 : fill;
      end
    end else if (!in_range) begin
      sts = STS_RANGE;
    end else begin
      cnt = ref_rd;
      unique case (op_q)
        OP_SEED: begin
          cnt      = '0;
          push_req = 1'b1;
        end
        OP_FREE: begin
          cnt      = dec;
          push_req = (dec == '0);
        end
        OP_INC: begin
          if (ref_rd == CNT_MAX) sts = STS_LIMIT;
          else cnt = ref_rd + 1'b1;
        end
        OP_DEC: begin
          if (ref_rd == '0) sts = STS_LIMIT;
          else cnt = dec;
        end
        default: ;
      endcase
      ref_wd = cnt;
      ref_we = go;
      if (push_req) begin
        if (fill == FILL_MAX) begin
          sts = STS_FULL;
        end else begin
          do_push   = go;
          fill_next = go ? fill + 1'b1 : fill;
        end
      end
    end
  end

  // count table: clearing sweep, read-modify-write
  always_ff @(posedge clk) begin
    if (clr_we) begin
      ref_mem[clr_addr] <= '0;
    end else if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (accept) begin
      ref_rd <= ref_mem[AW'(req.frame)];
    end
  end

  // free stack: top entry read on accept, push on write-back
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[AW'(fill)] <= frame_q;
    end
    if (accept) begin
      stack_rd <= stack_mem[AW'(fill - 1'b1)];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status  <= sts;
      out_frame   <= fout;
      out_refcnt  <= REFCNT_W'(cnt);
      out_freecnt <= FREECNT_W'(fill_next);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.frame_out  = out_frame;
  assign rsp.ref_count  = out_refcnt;
  assign rsp.free_count = out_freecnt;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("free list fill beyond capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill) || fill == $past(fill) + 1'b1 ||
                     fill == $past(fill) - 1'b1))
    else $error("free list fill moved by more than one");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready)
    else $error("word accepted during count table clear");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted word not executed");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (go && sts == STS_FULL) |-> fill == FILL_MAX)
    else $error("full status with room on the free list");

endmodule

// ----- test/page_frame_allocator_refcount_checker.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_checker: result checker of the frame allocator
// Watches the request, response and register ports and keeps its own copy of
// the free list, the count table and the usable floor. It computes the result
// of every accepted request word and compares each response word with the
// oldest result still waiting.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_checker import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pfa_req_if                 req,
  pfa_rsp_if                 rsp,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  FRAME_COUNT = 4096;
  localparam logic [REFCNT_W-1:0] COUNT_MAX   = '1;
  localparam int                  SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [FRAME_W-1:0]   frame;
    logic [REFCNT_W-1:0]  count;
    logic [FREECNT_W-1:0] list_depth;
  } result_t;

  // allocator state as this checker sees it
  logic [FRAME_W-1:0]   free_list [FRAME_COUNT];
  logic [REFCNT_W-1:0]  counts    [FRAME_COUNT];
  logic [FREECNT_W-1:0] fill;
  logic [FRAME_W-1:0]   floor_reg;

  result_t results_due [$];
  int      fail_total = 0;
  int      shown      = 0;

  // push onto the free list; a full list drops the frame
  function automatic bit push_free(input logic [FRAME_W-1:0] fr);
    if (fill >= FRAME_COUNT) return 1'b0;
    free_list[fill[FRAME_W-1:0]] = fr;
    fill = fill + 1'b1;
    return 1'b1;
  endfunction

  // carry out one request on the local state and give the result word
  function automatic result_t apply_operation(input logic [OP_W-1:0] op,
                                              input logic [FRAME_W-1:0] fr);
    result_t             r;
    logic [REFCNT_W-1:0] c;
    r.status = STS_OK;
    r.frame  = fr;
    r.count  = '0;
    if (op == OP_ALLOC) begin
      if (fill == 0) begin
        r.status = STS_EMPTY;
        r.frame  = '0;
      end else begin
        fill = fill - 1'b1;
        r.frame = free_list[fill[FRAME_W-1:0]];
        counts[r.frame] = REFCNT_W'(1);
        r.count = REFCNT_W'(1);
      end
    end else if (fr < floor_reg) begin
      // 12-bit frames never reach the table size, only the floor rejects
      r.status = STS_RANGE;
    end else begin
      c = counts[fr];
      case (op)
        OP_SEED: begin
          c = '0;
          if (!push_free(fr)) r.status = STS_FULL;
        end
        OP_FREE: begin
          if (c != 0) c = c - 1'b1;
          // a count already at zero still pushes the frame
          if (c == 0 && !push_free(fr)) r.status = STS_FULL;
        end
        OP_INC: begin
          if (c == COUNT_MAX) r.status = STS_LIMIT;
          else c = c + 1'b1;
        end
        OP_DEC: begin
          if (c == 0) r.status = STS_LIMIT;
          else c = c - 1'b1;
        end
        default: ;  // read, and the spare codes act as read
      endcase
      counts[fr] = c;
      r.count = c;
    end
    r.list_depth = fill;
    return r;
  endfunction

  // track register writes, predict accepted words, compare results
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      results_due.delete();
      fill      = '0;
      floor_reg = '0;
      for (int i = 0; i < FRAME_COUNT; i++) counts[i] = '0;
    end else begin
      if (cfg_we) floor_reg = cfg_wdata;
      if (req.valid && req.ready)
        results_due.push_back(apply_operation(req.operation, req.frame));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.frame_out, rsp.ref_count, rsp.free_count};
        if (results_due.size() == 0) begin
          fail_total++;
          if (shown < SHOW_LIMIT) begin
            $display("%0t unexpected result word: status %0d frame %0d count %0d free %0d",
                     $realtime, got.status, got.frame, got.count, got.list_depth);
            shown++;
          end
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.frame !== want.frame ||
              got.count !== want.count || got.list_depth !== want.list_depth) begin
            fail_total++;
            if (shown < SHOW_LIMIT) begin
              $display("%0t result mismatch: exp status %0d frame %0d count %0d free %0d",
                       $realtime, want.status, want.frame, want.count, want.list_depth);
              $display("%0t                  got status %0d frame %0d count %0d free %0d",
                       $realtime, got.status, got.frame, got.count, got.list_depth);
              shown++;
            end
          end
        end
      end
    end
    errors  <= fail_total;
    pending <= results_due.size();
  end

endmodule

// ----- test/page_frame_allocator_refcount_top_test.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_top_test: stimulus and verdict
// Drives request words through phases of sender idling and receiver stalls,
// changes the usable floor between phases, and leaves the checking to the
// checker instance beside the allocator.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_top_test;
  import pfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              MAX_FRAME   = 4095;
  localparam int              HOLD_CYCLES = 300;
  localparam int              QUIET_LIMIT = 20000;
  localparam logic [OP_W-1:0] OP_SPARE_A  = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B  = 3'd7;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;
  int                 errors;
  int                 pending;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asked   = 0;
  int hold_done    = 0;
  int usable_floor = 0;
  int quiet_cycles = 0;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();

  page_frame_allocator_refcount_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  page_frame_allocator_refcount_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: random stalls, plus a long hold-off when asked
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL page_frame_allocator_refcount_top");
        $finish;
      end
    end
  end

  // offer one request word, after a random gap, and wait until it is taken
  task automatic send_word(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fr);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.frame     <= fr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_floor(input int value);
    usable_floor = value;
    cfg_we    <= 1'b1;
    cfg_wdata <= value[FRAME_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // any frame number
  function automatic logic [FRAME_W-1:0] any_frame();
    return FRAME_W'($urandom_range(MAX_FRAME));
  endfunction

  // a frame from the few just above the floor
  function automatic logic [FRAME_W-1:0] pool_frame();
    int span;
    span = MAX_FRAME - usable_floor;
    if (span > 7) span = 7;
    return FRAME_W'(usable_floor + $urandom_range(span));
  endfunction

  // mostly pool frames so counts build up, now and then any frame
  function automatic logic [FRAME_W-1:0] pick_frame();
    if ($urandom_range(9) < 7) return pool_frame();
    return any_frame();
  endfunction

  // frame lifetimes, allocate/reference/free chains and some noise
  task automatic run_traffic(input int count);
    int                 sent;
    int                 kind;
    int                 refs;
    logic [FRAME_W-1:0] f;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      f    = pick_frame();
      if (kind < 55) begin
        refs = $urandom_range(3);
        send_word(OP_SEED, f);
        repeat (refs) send_word(OP_INC, f);
        send_word(OP_READ, f);
        send_word(OP_ALLOC, any_frame());
        repeat (refs + 1) send_word(OP_FREE, f);
        sent += 2 * refs + 4;
      end else if (kind < 80) begin
        send_word(OP_ALLOC, any_frame());
        send_word(OP_INC, f);
        send_word(OP_DEC, f);
        send_word(OP_FREE, f);
        sent += 4;
      end else begin
        send_word(OP_W'($urandom_range(7)), any_frame());
        sent++;
      end
    end
  endtask

  // edges of the fields, every operation and the odd cases, floor at 16
  task automatic run_directed();
    send_word(OP_ALLOC, 12'h000);     // empty list
    send_word(OP_DEC, 12'd20);        // decrement at zero
    send_word(OP_READ, 12'h000);      // below floor
    send_word(OP_INC, 12'd15);        // just below floor
    send_word(OP_SEED, 12'd16);       // floor itself
    send_word(OP_SEED, 12'hFFF);
    send_word(OP_INC, 12'hFFF);
    send_word(OP_INC, 12'hFFF);
    send_word(OP_FREE, 12'hFFF);      // still referenced, no push
    send_word(OP_FREE, 12'hFFF);      // last reference, pushed
    send_word(OP_FREE, 12'hFFF);      // count already zero, pushed again
    send_word(OP_SPARE_A, 12'd16);
    send_word(OP_SPARE_B, 12'hAAA);
    send_word(OP_ALLOC, 12'hFFF);
    send_word(OP_ALLOC, 12'h555);
    send_word(OP_ALLOC, 12'h000);
    send_word(OP_DEC, 12'hFFF);
    send_word(OP_SEED, 12'hAAA);
    send_word(OP_INC, 12'hAAA);
    send_word(OP_SEED, 12'hAAA);      // seed clears the count
    send_word(OP_READ, 12'h555);
    repeat (4) send_word(OP_ALLOC, 12'h000);
  endtask

  // count driven to its top and held there, then a few steps back
  task automatic run_extremes();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'(usable_floor);
    send_word(OP_SEED, f);
    repeat (256) send_word(OP_INC, f);
    repeat (2) send_word(OP_DEC, f);
    send_word(OP_FREE, f);
    send_word(OP_INC, f);
    repeat (4) send_word(OP_ALLOC, any_frame());
    send_word(OP_SEED, f);
  endtask

  // phases
  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_READ;
    req_ch.frame     <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_floor(16);
    run_directed();
    drain();

    write_floor(MAX_FRAME);
    tx_idle_pct = 80;
    run_traffic(25);
    drain();

    write_floor($urandom_range(MAX_FRAME - 1, 1));
    tx_idle_pct  = 0;
    rx_stall_pct = 80;
    hold_asked <= hold_asked + 1;
    run_traffic(30);
    drain();

    write_floor(0);
    tx_idle_pct  = 32;
    rx_stall_pct = 32;
    run_traffic(25);
    drain();

    write_floor($urandom_range(100, 1));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_extremes();
    drain();

    write_floor($urandom_range(200));
    tx_idle_pct  = 32;
    rx_stall_pct = 32;
    hold_asked <= hold_asked + 1;
    run_traffic(30);
    drain();

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS page_frame_allocator_refcount_top");
    end else begin
      $display("FAIL page_frame_allocator_refcount_top");
    end
    $finish;
  end

endmodule
